[rtl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Every use samples on the rising edge of clock and is switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define MFTD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// The condition must never be true.
`define MFTD_ASSERT_NEVER(name, cond, msg) \
   `MFTD_ASSERT(name, !(cond), msg)

`endif

[rtl/mftd_pkg.sv]
// Shared types and constants for the marked frame TLV deframer.
// No dependencies; the deframer top, parser and response stage import this package.
package mftd_pkg;

   // Frame marker, big endian on the wire
   localparam logic [31:0] FRAME_MARKER = 32'h41C9_0FD4;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
   localparam logic [1:0] KIND_OPTION     = 2'd1;
   localparam logic [1:0] KIND_FRAME_END  = 2'd2;
   localparam logic [1:0] KIND_BAD_MARKER = 2'd3;

   // Address family codes
   localparam logic [1:0] FAMILY_UNKNOWN = 2'd0;
   localparam logic [1:0] FAMILY_IPV4    = 2'd1;
   localparam logic [1:0] FAMILY_IPV6    = 2'd2;

   // One result item as it leaves the parser
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  address_family;
      logic [15:0] payload_len;
      logic [3:0]  option_key;
      logic [15:0] option_len;
      logic [7:0]  value_byte;
      logic [15:0] byte_index;
      logic        value_last;
      logic        frame_end;
   } rsp_data_type;

endpackage

[rtl/mftd_if.sv]
// Valid/ready channel interfaces for the deframer request and response streams.
// Depends on nothing; field names follow the block's item fields.
interface mftd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       connection_restart;

   modport source (output valid, output stream_byte, output connection_restart,
                   input ready);
   modport sink   (input valid, input stream_byte, input connection_restart,
                   output ready);
endinterface

interface mftd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [1:0]  address_family;
   logic [15:0] payload_len;
   logic [3:0]  option_key;
   logic [15:0] option_len;
   logic [7:0]  value_byte;
   logic [15:0] byte_index;
   logic        value_last;
   logic        frame_end;

   modport source (output valid, output result_kind, output address_family,
                   output payload_len, output option_key, output option_len,
                   output value_byte, output byte_index, output value_last,
                   output frame_end, input ready);
   modport sink   (input valid, input result_kind, input address_family,
                   input payload_len, input option_key, input option_len,
                   input value_byte, input byte_index, input value_last,
                   input frame_end, output ready);
endinterface

[rtl/marked_frame_tlv_deframer.sv]
// Marked frame TLV deframer: parses one stream byte per request and returns
// payload and option value bytes. It accepts one request every cycle while
// request ready is high; a result appears on the response channel in the cycle
// after acceptance when the output register is free, otherwise it waits in the
// skid entry behind the held one. The output register plus one skid entry let
// requests keep flowing while one response waits; request ready drops only while
// both hold results. Requests that produce no response (header, padding, option
// id and length bytes) still need a request each. There is no clearing pass
// after reset. Depends on mftd_pkg, mftd_if, mftd_parser and mftd_rsp_stage.

module marked_frame_tlv_deframer (
   input  logic       clock,
   input  logic       reset,
   mftd_req_if.sink   req_chan,
   mftd_rsp_if.source rsp_chan
);
   import mftd_pkg::*;

   logic         accept;
   logic         can_accept;
   logic         res_valid;
   rsp_data_type res_data;

   assign req_chan.ready = can_accept;
   assign accept         = req_chan.valid & can_accept;

   // Parser state and per-byte decode
   mftd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .stream_byte        (req_chan.stream_byte),
      .connection_restart (req_chan.connection_restart),
      .res_valid          (res_valid),
      .res_data           (res_data)
   );

   // Response register and skid
   mftd_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (accept & res_valid),
      .push_data  (res_data),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );

endmodule

[rtl/mftd_parser.sv]
// Per-byte frame parser: state registers and the next-state/result logic.
// Depends on mftd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mftd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            stream_byte,
   input  logic                  connection_restart,
   output logic                  res_valid,
   output mftd_pkg::rsp_data_type res_data
);
   import mftd_pkg::*;

   // Parse phases
   localparam logic [3:0] PH_HUNT    = 4'd0;
   localparam logic [3:0] PH_SIZE    = 4'd1;
   localparam logic [3:0] PH_VERS    = 4'd2;
   localparam logic [3:0] PH_PLEN    = 4'd3;
   localparam logic [3:0] PH_PAYLOAD = 4'd4;
   localparam logic [3:0] PH_PAD     = 4'd5;
   localparam logic [3:0] PH_OID     = 4'd6;
   localparam logic [3:0] PH_OLEN    = 4'd7;
   localparam logic [3:0] PH_OVAL    = 4'd8;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] count;
   } pad_step_type;

   // Move to padding (or straight to the next option id) after a field of length len
   function automatic pad_step_type pad_step(input logic [2:0] len);
      pad_step_type step;
      logic [2:0]   pad;
      pad = 3'd0 - len;
      if (pad == 3'd0) begin
         step.phase = PH_OID;
         step.count = '0;
      end else begin
         step.phase = PH_PAD;
         step.count = {13'd0, pad};
      end
      return step;
   endfunction

   // Known option ids map to a compact key, anything else is unknown
   function automatic logic [3:0] key_code(input logic [31:0] id);
      logic [31:0] rel;
      rel = id - 32'd196;
      if (id >= 32'd1 && id <= 32'd4) begin
         return 4'(id - 32'd1);
      end else if (id >= 32'd200 && id <= 32'd206) begin
         return rel[3:0];
      end else begin
         return 4'd11;
      end
   endfunction

   logic [3:0]  phase_ff,  phase_in;
   logic [31:0] marker_ff, marker_in;
   logic [15:0] count_ff,  count_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] plen_ff,   plen_in;
   logic [31:0] oid_ff,    oid_in;
   logic [31:0] olen_ff,   olen_in;
   logic [1:0]  family_ff, family_in;
   logic        drop_ff,   drop_in;

   logic        data;
   logic        fin;
   logic        last;
   logic        bad;
   logic [1:0]  kind;
   logic [3:0]  key;
   logic [15:0] olen_out;
   logic [15:0] idx;
   logic [15:0] remain_dec;
   logic [15:0] total;
   logic [31:0] olen_shift;
   logic [31:0] olen_clip;
   pad_step_type step;

   // Next state and result for the byte at the input
   always_comb begin
      phase_in   = phase_ff;
      marker_in  = marker_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      plen_in    = plen_ff;
      oid_in     = oid_ff;
      olen_in    = olen_ff;
      family_in  = family_ff;
      drop_in    = drop_ff;
      data       = 1'b0;
      fin        = 1'b0;
      last       = 1'b0;
      bad        = 1'b0;
      kind       = KIND_PAYLOAD;
      key        = '0;
      olen_out   = '0;
      idx        = '0;
      remain_dec = remain_ff - 16'd1;
      total      = remain_ff | {8'd0, stream_byte};
      olen_shift = {olen_ff[23:0], stream_byte};
      olen_clip  = (olen_shift > {16'd0, remain_dec}) ? {16'd0, remain_dec} : olen_shift;
      step       = pad_step(3'd0);

      if (connection_restart) begin
         phase_in  = PH_HUNT;
         marker_in = '0;
         count_in  = '0;
         remain_in = '0;
         plen_in   = '0;
         oid_in    = '0;
         olen_in   = '0;
         family_in = FAMILY_UNKNOWN;
         drop_in   = 1'b0;
      end else if (!drop_ff) begin
         if (phase_ff == PH_HUNT) begin
            // Marker hunt: four bytes, then match or give up on the connection
            marker_in = {marker_ff[23:0], stream_byte};
            count_in  = count_ff + 16'd1;
            if (count_ff >= 16'd3) begin
               count_in = '0;
               if (marker_in == FRAME_MARKER) begin
                  phase_in  = PH_SIZE;
                  plen_in   = '0;
                  oid_in    = '0;
                  olen_in   = '0;
                  family_in = FAMILY_UNKNOWN;
               end else begin
                  drop_in = 1'b1;
                  bad     = 1'b1;
               end
            end
         end else if (phase_ff == PH_SIZE) begin
            // Frame size, two bytes; it counts itself too
            if (count_ff == 16'd0) begin
               remain_in = {stream_byte, 8'd0};
               count_in  = 16'd1;
            end else if (total > 16'd2) begin
               remain_in = total - 16'd2;
               phase_in  = PH_VERS;
               count_in  = '0;
            end else begin
               fin = 1'b1;
            end
         end else begin
            remain_in = remain_dec;
            fin       = (remain_dec == 16'd0);
            unique case (phase_ff)
               PH_VERS: begin
                  count_in = count_ff + 16'd1;
                  if (count_ff >= 16'd3) begin
                     phase_in = PH_PLEN;
                     count_in = '0;
                  end
               end
               PH_PLEN: begin
                  plen_in  = {plen_ff[7:0], stream_byte};
                  count_in = count_ff + 16'd1;
                  if (count_ff >= 16'd1) begin
                     count_in = '0;
                     if (plen_in == 16'd0) begin
                        step     = pad_step(3'd0);
                        phase_in = step.phase;
                        count_in = step.count;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  idx = count_ff;
                  if (count_ff == 16'd0) begin
                     if (stream_byte[7:4] == 4'd4) begin
                        family_in = FAMILY_IPV4;
                     end else if (stream_byte[7:4] == 4'd6) begin
                        family_in = FAMILY_IPV6;
                     end else begin
                        family_in = FAMILY_UNKNOWN;
                     end
                  end
                  data     = 1'b1;
                  kind     = KIND_PAYLOAD;
                  last     = (({1'b0, count_ff} + 17'd1) == {1'b0, plen_ff});
                  count_in = count_ff + 16'd1;
                  if (last) begin
                     step     = pad_step(plen_ff[2:0]);
                     phase_in = step.phase;
                     count_in = step.count;
                  end
               end
               PH_PAD: begin
                  count_in = count_ff - 16'd1;
                  if (count_in == 16'd0) begin
                     phase_in = PH_OID;
                  end
               end
               PH_OID: begin
                  oid_in   = {oid_ff[23:0], stream_byte};
                  count_in = count_ff + 16'd1;
                  if (count_ff >= 16'd3) begin
                     phase_in = PH_OLEN;
                     count_in = '0;
                  end
               end
               PH_OLEN: begin
                  olen_in  = olen_shift;
                  count_in = count_ff + 16'd1;
                  if (count_ff >= 16'd3) begin
                     // Clip the value to what is left of the frame
                     olen_in  = olen_clip;
                     count_in = '0;
                     if (olen_clip == 32'd0) begin
                        step     = pad_step(3'd0);
                        phase_in = step.phase;
                        count_in = step.count;
                     end else begin
                        phase_in = PH_OVAL;
                     end
                  end
               end
               default: begin
                  // Option value bytes
                  idx      = count_ff;
                  data     = 1'b1;
                  kind     = KIND_OPTION;
                  key      = key_code(oid_ff);
                  olen_out = olen_ff[15:0];
                  last     = (({16'd0, count_ff} + 32'd1) == olen_ff);
                  count_in = count_ff + 16'd1;
                  if (last) begin
                     step     = pad_step(olen_ff[2:0]);
                     phase_in = step.phase;
                     count_in = step.count;
                  end
               end
            endcase
         end

         // Frame boundary wins over everything else
         if (fin) begin
            phase_in  = PH_HUNT;
            marker_in = '0;
            count_in  = '0;
            remain_in = '0;
         end
      end
   end

   // Result assembly
   always_comb begin
      res_valid = data | fin | bad;
      res_data  = '0;
      if (bad) begin
         res_data.result_kind = KIND_BAD_MARKER;
      end else begin
         res_data.result_kind    = data ? kind : KIND_FRAME_END;
         res_data.address_family = family_in;
         res_data.payload_len    = plen_in;
         res_data.frame_end      = fin;
         if (data) begin
            res_data.option_key = key;
            res_data.option_len = olen_out;
            res_data.value_byte = stream_byte;
            res_data.byte_index = idx;
            res_data.value_last = last | fin;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         marker_ff <= '0;
         count_ff  <= '0;
         remain_ff <= '0;
         plen_ff   <= '0;
         oid_ff    <= '0;
         olen_ff   <= '0;
         family_ff <= FAMILY_UNKNOWN;
         drop_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         plen_ff   <= plen_in;
         oid_ff    <= oid_in;
         olen_ff   <= olen_in;
         family_ff <= family_in;
         drop_ff   <= drop_in;
      end
   end

   `MFTD_ASSERT(a_drop_freezes, (drop_ff && accept && !connection_restart) |=> ($stable(phase_ff) && $stable(count_ff) && $stable(marker_ff)), "parser moved while dropping")
   `MFTD_ASSERT(a_bad_sets_drop, (accept && res_valid && res_data.result_kind == KIND_BAD_MARKER) |=> drop_ff, "bad marker did not set drop")
   `MFTD_ASSERT(a_pad_range, (phase_ff == PH_PAD) |-> (count_ff != 16'd0 && count_ff < 16'd8), "pad count out of range")

endmodule

[rtl/mftd_rsp_stage.sv]
// Response output register with one skid entry, so the parser keeps taking
// bytes while a result waits. Depends on mftd_pkg, mftd_if and assert_macros.svh.
`include "assert_macros.svh"

module mftd_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mftd_pkg::rsp_data_type push_data,
   output logic                  can_accept,
   mftd_rsp_if.source            rsp_chan
);
   import mftd_pkg::*;

   logic         out_valid_ff,  out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_data_type out_data_ff,   out_data_in;
   rsp_data_type skid_data_ff,  skid_data_in;
   logic         take;

   assign take       = out_valid_ff & rsp_chan.ready;
   assign can_accept = ~skid_valid_ff;

   // Fill order: output register first, skid only when the output is stuck
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         out_valid_in = 1'b0;
      end
      if (take && skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else if (push && (!out_valid_ff || take)) begin
         out_valid_in = 1'b1;
         out_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result_kind    = out_data_ff.result_kind;
   assign rsp_chan.address_family = out_data_ff.address_family;
   assign rsp_chan.payload_len    = out_data_ff.payload_len;
   assign rsp_chan.option_key     = out_data_ff.option_key;
   assign rsp_chan.option_len     = out_data_ff.option_len;
   assign rsp_chan.value_byte     = out_data_ff.value_byte;
   assign rsp_chan.byte_index     = out_data_ff.byte_index;
   assign rsp_chan.value_last     = out_data_ff.value_last;
   assign rsp_chan.frame_end      = out_data_ff.frame_end;

   `MFTD_ASSERT_NEVER(a_skid_alone, skid_valid_ff && !out_valid_ff, "skid holds a result ahead of output")
   `MFTD_ASSERT(a_skid_holds, (skid_valid_ff && !take) |=> (skid_valid_ff && $stable(skid_data_ff)), "skid entry lost or changed")
   `MFTD_ASSERT_NEVER(a_push_when_full, push && skid_valid_ff, "result pushed into a full stage")

endmodule
